>>> src/hnm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types, constants and helpers of the height-to-normal-map block.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int HEIGHT_BITS      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int STRENGTH_W       = 16;
  localparam int COL_W            = 10;
  localparam int ROW_W            = 12;
  localparam int DIFF_W           = HEIGHT_BITS + 1;
  localparam int SQ_W             = 2 * HEIGHT_BITS;
  localparam int SUM_W            = SQ_W + 2;
  localparam int QUO_W            = 2 * NORMAL_FRAC_BITS + 3;
  localparam int ROOT_W           = NORMAL_FRAC_BITS + 2;
  localparam int MAG_W            = NORMAL_FRAC_BITS + 1;
  localparam int NORM_W           = MAG_W + 1;
  localparam int MAX_JOBS         = 3;

  localparam logic [10:0] RESET_WIDTH    = 11'd1024;
  localparam logic [12:0] RESET_HEIGHT   = 13'd1024;
  localparam logic [15:0] RESET_STRENGTH = 16'd9830;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_STRENGTH     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CENTER,
    F_EAST,
    F_EMIT
  } fetch_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_SUM,
    N_LOAD,
    N_DIV,
    N_ROOT,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [15:0] strength;
  } cfg_t;

  // One pixel whose normal is to be formed: position and the two differences.
  typedef struct packed {
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic [MAG_W-1:0]         norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     last;
  } res_t;

  function automatic job_t make_job(input logic [COL_W-1:0] col,
                                    input logic [ROW_W-1:0] row,
                                    input logic [HEIGHT_BITS-1:0] west,
                                    input logic [HEIGHT_BITS-1:0] east,
                                    input logic [HEIGHT_BITS-1:0] north,
                                    input logic [HEIGHT_BITS-1:0] south);
    job_t j;
    j.col  = col;
    j.row  = row;
    j.dx   = $signed({1'b0, west}) - $signed({1'b0, east});
    j.dz   = $signed({1'b0, south}) - $signed({1'b0, north});
    j.last = 1'b0;
    return j;
  endfunction

endpackage
`default_nettype wire

>>> src/hnm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_if
// Stream interfaces for height samples in and normal words out.
// ----------------------------------------------------------------------------
interface hnm_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface hnm_normal_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] norm_x;
  logic [14:0]        norm_y;
  logic signed [15:0] norm_z;
  logic [9:0]         out_col;
  logic [11:0]        out_row;
  logic               last_of_run;

  modport source (output valid, output norm_x, output norm_y, output norm_z,
                  output out_col, output out_row, output last_of_run, input ready);
  modport sink (input valid, input norm_x, input norm_y, input norm_z,
                input out_col, input out_row, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> src/hnm_fetch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_fetch
// Line stores, raster counters and neighbor taps. Each sample is read,
// modified and written back, then its pixel jobs are handed on.
// ----------------------------------------------------------------------------
module hnm_fetch #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hnm_pkg::cfg_t                    cfg,
  input  logic                             start,
  input  logic [hnm_pkg::HEIGHT_BITS-1:0]  height,
  output logic                             idle,
  output logic                             job_valid,
  input  logic                             job_ready,
  output hnm_pkg::job_t                    job
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int HB = hnm_pkg::HEIGHT_BITS;
  localparam int RW = hnm_pkg::ROW_W;
  localparam int KW = hnm_pkg::COL_W;

  hnm_pkg::fetch_state_t state, state_next;

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [CW-1:0] x_q;
  logic [RW-1:0] y_q;
  logic [HB-1:0] h_q;
  logic          last_col_q;
  logic          last_row_q;
  logic [HB-1:0] center_q;
  logic [HB-1:0] north_q;
  logic [HB-1:0] west_tap;
  logic [HB-1:0] prev_h;
  logic [HB-1:0] prev2_h;

  logic [HB-1:0] recent_mem [MAX_WIDTH];
  logic [HB-1:0] older_mem  [MAX_WIDTH];
  logic [HB-1:0] recent_q;
  logic [HB-1:0] older_q;
  logic [CW-1:0] rd_addr;
  logic          mem_we;

  hnm_pkg::job_t jobs      [hnm_pkg::MAX_JOBS];
  hnm_pkg::job_t jobs_next [hnm_pkg::MAX_JOBS];
  logic [1:0]    job_cnt;
  logic [1:0]    job_cnt_next;
  logic [1:0]    emit_idx;

  logic [13:0]   w_clamp;
  logic [CW-1:0] wlast;
  logic [12:0]   ht_clamp;
  logic [RW-1:0] htlast;
  logic          last_col;
  logic          last_row;

  logic [HB-1:0] east;
  logic [HB-1:0] west;
  logic [HB-1:0] north;
  logic [HB-1:0] flush_west;
  logic [HB-1:0] edge_west;

  always_comb begin
    w_clamp = {3'b000, cfg.image_width};
    if (w_clamp < 14'd2) begin
      w_clamp = 14'd2;
    end
    if (w_clamp > 14'(MAX_WIDTH)) begin
      w_clamp = 14'(MAX_WIDTH);
    end
    wlast = CW'(w_clamp - 14'd1);
    ht_clamp = cfg.image_height;
    if (ht_clamp < 13'd2) begin
      ht_clamp = 13'd2;
    end else if (ht_clamp > 13'd4096) begin
      ht_clamp = 13'd4096;
    end
    htlast   = RW'(ht_clamp - 13'd1);
    last_col = col_cnt >= wlast;
    last_row = row_cnt >= htlast;
  end

  // The east neighbor is read one address past the center, except at the
  // row end where the center stands in for it.
  assign rd_addr = (state == hnm_pkg::F_CENTER) ?
                   (last_col_q ? x_q : x_q + CW'(1)) : col_cnt;
  assign mem_we  = (state == hnm_pkg::F_EAST);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      recent_mem[x_q] <= h_q;
      older_mem[x_q]  <= center_q;
    end else begin
      recent_q <= recent_mem[rd_addr];
      older_q  <= older_mem[rd_addr];
    end
  end

  // Pixel jobs for this sample. On the final row the previous column and,
  // at the row end, the current column are also flushed. The previous samples
  // of the row sit in taps, so no extra store reads are needed for them.
  always_comb begin
    logic [1:0] n;
    n          = 2'd0;
    east       = last_col_q ? center_q : recent_q;
    west       = (x_q == '0) ? center_q : west_tap;
    north      = (y_q <= RW'(1)) ? center_q : north_q;
    flush_west = (x_q > CW'(1)) ? prev2_h : prev_h;
    edge_west  = (x_q != '0) ? prev_h : h_q;
    for (int i = 0; i < hnm_pkg::MAX_JOBS; i++) begin
      jobs_next[i] = jobs[i];
    end
    if (y_q != '0) begin
      jobs_next[n] = hnm_pkg::make_job(KW'(x_q), y_q - RW'(1), west, east, north, h_q);
      n = n + 2'd1;
      if (last_row_q) begin
        if (x_q != '0) begin
          jobs_next[n] = hnm_pkg::make_job(KW'(x_q - CW'(1)), y_q, flush_west, h_q,
                                           west_tap, prev_h);
          n = n + 2'd1;
        end
        if (last_col_q) begin
          jobs_next[n] = hnm_pkg::make_job(KW'(x_q), y_q, edge_west, h_q, center_q, h_q);
          n = n + 2'd1;
        end
      end
    end
    job_cnt_next = n;
  end

  always_comb begin
    state_next = state;
    case (state)
      hnm_pkg::F_IDLE: begin
        if (start) begin
          state_next = hnm_pkg::F_CENTER;
        end
      end
      hnm_pkg::F_CENTER: begin
        state_next = hnm_pkg::F_EAST;
      end
      hnm_pkg::F_EAST: begin
        state_next = (job_cnt_next != 2'd0) ? hnm_pkg::F_EMIT : hnm_pkg::F_IDLE;
      end
      hnm_pkg::F_EMIT: begin
        if (job_ready && (emit_idx == job_cnt - 2'd1)) begin
          state_next = hnm_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = hnm_pkg::F_IDLE;
      end
    endcase
  end

  always_comb begin
    idle      = (state == hnm_pkg::F_IDLE);
    job_valid = (state == hnm_pkg::F_EMIT);
    job       = jobs[emit_idx];
    job.last  = (emit_idx == job_cnt - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hnm_pkg::F_IDLE;
      col_cnt  <= '0;
      row_cnt  <= '0;
      west_tap <= '0;
      prev_h   <= '0;
      prev2_h  <= '0;
      job_cnt  <= 2'd0;
      emit_idx <= 2'd0;
    end else begin
      state <= state_next;
      case (state)
        hnm_pkg::F_EAST: begin
          west_tap <= center_q;
          prev2_h  <= prev_h;
          prev_h   <= h_q;
          job_cnt  <= job_cnt_next;
          emit_idx <= 2'd0;
          if (last_col_q) begin
            col_cnt <= '0;
            row_cnt <= last_row_q ? '0 : y_q + RW'(1);
          end else begin
            col_cnt <= x_q + CW'(1);
          end
        end
        hnm_pkg::F_EMIT: begin
          if (job_ready) begin
            emit_idx <= emit_idx + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == hnm_pkg::F_IDLE) && start) begin
      x_q        <= col_cnt;
      y_q        <= row_cnt;
      h_q        <= height;
      last_col_q <= last_col;
      last_row_q <= last_row;
    end
    if (state == hnm_pkg::F_CENTER) begin
      center_q <= recent_q;
      north_q  <= older_q;
    end
    if (state == hnm_pkg::F_EAST) begin
      for (int i = 0; i < hnm_pkg::MAX_JOBS; i++) begin
        jobs[i] <= jobs_next[i];
      end
    end
  end

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == hnm_pkg::F_EMIT) |-> (job_cnt != 2'd0) && (emit_idx < job_cnt))
    else $error("pixel job index past the job count");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == hnm_pkg::F_EAST) && last_col_q |=> (col_cnt == '0))
    else $error("column counter did not wrap at the row end");

endmodule
`default_nettype wire

>>> src/hnm_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_norm
// Normalizer: forms the squared length, then for each component a bit-serial
// division and a bit-serial square root give the exactly rounded magnitude.
// ----------------------------------------------------------------------------
module hnm_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [hnm_pkg::STRENGTH_W-1:0] strength,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  hnm_pkg::job_t                  job,
  output logic                           res_valid,
  input  logic                           res_ready,
  output hnm_pkg::res_t                  res
);

  localparam int HB    = hnm_pkg::HEIGHT_BITS;
  localparam int SQW   = hnm_pkg::SQ_W;
  localparam int SW    = hnm_pkg::SUM_W;
  localparam int QW    = hnm_pkg::QUO_W;
  localparam int RTW   = hnm_pkg::ROOT_W;
  localparam int MW    = hnm_pkg::MAG_W;
  localparam int NW    = hnm_pkg::NORM_W;
  localparam int DW    = hnm_pkg::DIFF_W;
  localparam int CNT_W = $clog2(QW);
  localparam int BIT_W = $clog2(RTW);

  hnm_pkg::norm_state_t state, state_next;
  hnm_pkg::comp_t       comp;

  logic                      neg_x;
  logic                      neg_z;
  logic [hnm_pkg::COL_W-1:0] col;
  logic [hnm_pkg::ROW_W-1:0] row;
  logic                      last;
  logic [HB-1:0]             ax;
  logic [HB-1:0]             az;
  logic [HB-1:0]             sy;
  logic [SQW-1:0]            sq_x;
  logic [SQW-1:0]            sq_y;
  logic [SQW-1:0]            sq_z;
  logic [SQW-1:0]            sq_sel;
  logic [SW-1:0]             sum;
  logic [SW-1:0]             rem;
  logic [QW-1:0]             quo;
  logic [CNT_W-1:0]          cnt;
  logic [RTW-1:0]            root;
  logic [BIT_W-1:0]          bit_idx;
  logic [MW-1:0]             mag_x;
  logic [MW-1:0]             mag_y;
  logic [MW-1:0]             mag_z;

  logic [SW:0]               rem_sh;
  logic                      rem_ge;
  logic [SW:0]               rem_new;
  logic [RTW-1:0]            cand;
  logic [2*RTW-1:0]          cand_sq;
  logic                      take;
  logic [RTW-1:0]            root_new;
  logic [RTW:0]              root_inc;
  logic [MW-1:0]             mag_new;
  logic [DW-1:0]             abs_dx;
  logic [DW-1:0]             abs_dz;

  // The quotient is floor(a^2 * 4^(F+1) / sum); the dividend has a single
  // nonzero bit below those already in the remainder.
  always_comb begin
    rem_sh   = {rem, (cnt == CNT_W'(QW - 1)) ? sq_sel[0] : 1'b0};
    rem_ge   = rem_sh >= {1'b0, sum};
    rem_new  = rem_ge ? rem_sh - {1'b0, sum} : rem_sh;
    cand     = root | (RTW'(1) << bit_idx);
    cand_sq  = cand * cand;
    take     = cand_sq <= {{(2 * RTW - QW){1'b0}}, quo};
    root_new = take ? cand : root;
    // Half of the root plus one, rounded down, gives the rounded magnitude.
    root_inc = {1'b0, root_new} + {{RTW{1'b0}}, 1'b1};
    mag_new  = root_inc[MW:1];
    abs_dx   = job.dx[DW-1] ? DW'(-job.dx) : DW'(job.dx);
    abs_dz   = job.dz[DW-1] ? DW'(-job.dz) : DW'(job.dz);
  end

  always_comb begin
    state_next = state;
    case (state)
      hnm_pkg::N_IDLE: begin
        if (job_valid) begin
          state_next = hnm_pkg::N_SQ;
        end
      end
      hnm_pkg::N_SQ: begin
        state_next = hnm_pkg::N_SUM;
      end
      hnm_pkg::N_SUM: begin
        state_next = hnm_pkg::N_LOAD;
      end
      hnm_pkg::N_LOAD: begin
        state_next = (sum == '0) ? hnm_pkg::N_DONE : hnm_pkg::N_DIV;
      end
      hnm_pkg::N_DIV: begin
        if (cnt == '0) begin
          state_next = hnm_pkg::N_ROOT;
        end
      end
      hnm_pkg::N_ROOT: begin
        if (bit_idx == '0) begin
          state_next = (comp == hnm_pkg::COMP_Z) ? hnm_pkg::N_DONE : hnm_pkg::N_LOAD;
        end
      end
      hnm_pkg::N_DONE: begin
        if (res_ready) begin
          state_next = hnm_pkg::N_IDLE;
        end
      end
      default: begin
        state_next = hnm_pkg::N_IDLE;
      end
    endcase
  end

  always_comb begin
    job_ready  = (state == hnm_pkg::N_IDLE);
    res_valid  = (state == hnm_pkg::N_DONE);
    res.norm_x = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    res.norm_y = mag_y;
    res.norm_z = neg_z ? -$signed({1'b0, mag_z}) : $signed({1'b0, mag_z});
    res.col    = col;
    res.row    = row;
    res.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hnm_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hnm_pkg::N_IDLE: begin
        if (job_valid) begin
          neg_x <= job.dx[DW-1];
          neg_z <= job.dz[DW-1];
          ax    <= HB'(abs_dx);
          az    <= HB'(abs_dz);
          sy    <= HB'(strength);
          col   <= job.col;
          row   <= job.row;
          last  <= job.last;
        end
      end
      hnm_pkg::N_SQ: begin
        sq_x <= ax * ax;
        sq_y <= sy * sy;
        sq_z <= az * az;
      end
      hnm_pkg::N_SUM: begin
        sum  <= SW'(sq_x) + SW'(sq_y) + SW'(sq_z);
        comp <= hnm_pkg::COMP_X;
      end
      hnm_pkg::N_LOAD: begin
        if (sum == '0) begin
          // Zero vector: the normal points straight up.
          mag_x <= '0;
          mag_y <= MW'(1) << hnm_pkg::NORMAL_FRAC_BITS;
          mag_z <= '0;
        end
        case (comp)
          hnm_pkg::COMP_X: sq_sel <= sq_x;
          hnm_pkg::COMP_Y: sq_sel <= sq_y;
          default:         sq_sel <= sq_z;
        endcase
        case (comp)
          hnm_pkg::COMP_X: rem <= SW'(sq_x >> 1);
          hnm_pkg::COMP_Y: rem <= SW'(sq_y >> 1);
          default:         rem <= SW'(sq_z >> 1);
        endcase
        quo <= '0;
        cnt <= CNT_W'(QW - 1);
      end
      hnm_pkg::N_DIV: begin
        rem     <= SW'(rem_new);
        quo     <= {quo[QW-2:0], rem_ge};
        cnt     <= cnt - CNT_W'(1);
        root    <= '0;
        bit_idx <= BIT_W'(RTW - 1);
      end
      hnm_pkg::N_ROOT: begin
        root    <= root_new;
        bit_idx <= bit_idx - BIT_W'(1);
        if (bit_idx == '0) begin
          case (comp)
            hnm_pkg::COMP_X: begin
              mag_x <= mag_new;
              comp  <= hnm_pkg::COMP_Y;
            end
            hnm_pkg::COMP_Y: begin
              mag_y <= mag_new;
              comp  <= hnm_pkg::COMP_Z;
            end
            default: begin
              mag_z <= mag_new;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  a_rem_below_sum: assert property (@(posedge clk) disable iff (rst)
    (state == hnm_pkg::N_DIV) |-> (rem < sum))
    else $error("division remainder not below the squared length");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == hnm_pkg::N_DONE) |->
      (mag_x <= (MW'(1) << hnm_pkg::NORMAL_FRAC_BITS)) &&
      (mag_y <= (MW'(1) << hnm_pkg::NORMAL_FRAC_BITS)) &&
      (mag_z <= (MW'(1) << hnm_pkg::NORMAL_FRAC_BITS)))
    else $error("normal component exceeds one");

endmodule
`default_nettype wire

>>> src/height_to_normal_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// height_to_normal_map
// Central-difference normal map from a raster stream of height samples.
// ----------------------------------------------------------------------------
// Height samples enter in raster order and each pixel leaves one row later as a
// unit normal in signed Q1.14, with its column and row; on the final row a
// sample also releases the pixel before it and, at the row end, itself, and
// last_of_run marks the final word released by a sample. A sample passes through
// the line stores (center read, east read, write back), and each word then goes
// through the shared normalizer: the squared length (square, then sum) and, per
// component, one load, 31 division steps and 16 root steps. The normalizer sets
// the rate; a new sample is taken only once it has accepted every word of the
// previous one (up to three on the final row). The line stores need no clearing
// after reset. Registers: image_width at 0x0, image_height at 0x4, strength at
// 0x8; write them only while no word is outstanding.
// ----------------------------------------------------------------------------
module height_to_normal_map #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  hnm_sample_if.sink          samples,
  hnm_normal_if.source        normals
);

  hnm_pkg::cfg_t cfg;
  logic          cfg_we;
  logic          start;
  logic          fetch_idle;
  logic          job_valid;
  logic          job_ready;
  hnm_pkg::job_t job;
  logic          res_valid;
  logic          res_ready;
  hnm_pkg::res_t res;
  logic          out_valid;
  hnm_pkg::res_t out_word;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= hnm_pkg::RESET_WIDTH;
      cfg.image_height <= hnm_pkg::RESET_HEIGHT;
      cfg.strength     <= hnm_pkg::RESET_STRENGTH;
    end else if (cfg_we) begin
      case (hnm_pkg::reg_idx_t'(paddr[3:2]))
        hnm_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[10:0];
        hnm_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[12:0];
        hnm_pkg::REG_STRENGTH:     cfg.strength     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (hnm_pkg::reg_idx_t'(paddr[3:2]))
      hnm_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, cfg.image_width};
      hnm_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, cfg.image_height};
      hnm_pkg::REG_STRENGTH:     prdata = {16'd0, cfg.strength};
      default:                   prdata = 32'd0;
    endcase
  end

  assign samples.ready = fetch_idle;
  assign start         = samples.valid && samples.ready;

  hnm_fetch #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_fetch (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .height    (samples.height),
    .idle      (fetch_idle),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  hnm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .strength  (cfg.strength),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output word register: it frees the normalizer as soon as a word is parked.
  assign res_ready = !out_valid || normals.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (normals.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign normals.valid       = out_valid;
  assign normals.norm_x      = out_word.norm_x;
  assign normals.norm_y      = out_word.norm_y;
  assign normals.norm_z      = out_word.norm_z;
  assign normals.out_col     = out_word.col;
  assign normals.out_row     = out_word.row;
  assign normals.last_of_run = out_word.last;

  a_one_sample_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("second sample taken while the line stores are busy");

endmodule
`default_nettype wire
